/* rtl/lcsl_pkg.sv */
// Package for the LCS length engine: sizes, request codes and the
// controller/datapath command and status structs. No dependencies.
package lcsl_pkg;
	localparam int MAX_LEN = 256;
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int SYM_W = 8;

	typedef enum logic [1:0] {
		REQ_FIRST = 2'd0,
		REQ_SECOND = 2'd1,
		REQ_END = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef struct packed {
		logic store;
		logic row_start;
		logic row_step;
		logic clr_start;
		logic clr_step;
		logic rd_last;
		logic capture;
		logic [SYM_W-1:0] sym;
	} cmd_t;

	typedef struct packed {
		logic row_last;
		logic clr_last;
		logic empty;
	} sts_t;
endpackage

/* rtl/lcsl_datapath.sv */
// Datapath of the LCS length engine: symbol store, DP row memory, one
// shared cell that walks the row, result and overflow registers.
// Depends on lcsl_pkg.
module lcsl_datapath (
	input logic clk,
	input logic arst_n,
	input lcsl_pkg::cmd_t cmd,
	output lcsl_pkg::sts_t sts,
	output logic [lcsl_pkg::LEN_W-1:0] lcs_length,
	output logic overflow
);
	import lcsl_pkg::*;

	logic [SYM_W-1:0] str_mem [MAX_LEN];
	logic [LEN_W-1:0] row_mem [MAX_LEN];
	logic [LEN_W-1:0] flen_q;
	logic ovf_q;
	logic [IDX_W-1:0] idx_q;
	logic [SYM_W-1:0] sym_q;
	logic [LEN_W-1:0] diag_q, left_q, up_q, res_q;
	logic [SYM_W-1:0] str_rd_q;
	logic [LEN_W-1:0] v;
	logic [IDX_W-1:0] rd_idx;
	logic [LEN_W-1:0] last_idx;

	assign last_idx = flen_q - LEN_W'(1);
	assign sts.row_last = ({1'b0, idx_q} == last_idx);
	assign sts.clr_last = (idx_q == IDX_W'(MAX_LEN - 1));
	assign sts.empty = (flen_q == '0);

	// Next read address: start of row, the last stored entry, or the entry after the current one.
	assign rd_idx = cmd.row_start ? '0 :
		(cmd.rd_last ? last_idx[IDX_W-1:0] : idx_q + IDX_W'(1));

	always_comb begin
		v = (up_q > left_q) ? up_q : left_q;
		if (str_rd_q == sym_q && diag_q + LEN_W'(1) > v)
			v = diag_q + LEN_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.store && flen_q != LEN_W'(MAX_LEN))
			str_mem[flen_q[IDX_W-1:0]] <= cmd.sym;
		if (cmd.row_step)
			row_mem[idx_q] <= v;
		else if (cmd.clr_step)
			row_mem[idx_q] <= '0;
		up_q <= row_mem[rd_idx];
		str_rd_q <= str_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			sym_q <= '0;
			diag_q <= '0;
			left_q <= '0;
			res_q <= '0;
			overflow <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (flen_q == LEN_W'(MAX_LEN))
					ovf_q <= 1'b1;
				else
					flen_q <= flen_q + LEN_W'(1);
			end
			if (cmd.row_start) begin
				idx_q <= '0;
				sym_q <= cmd.sym;
				diag_q <= '0;
				left_q <= '0;
			end else if (cmd.row_step) begin
				idx_q <= idx_q + IDX_W'(1);
				diag_q <= up_q;
				left_q <= v;
			end
			if (cmd.capture) begin
				res_q <= sts.empty ? '0 : up_q;
				overflow <= ovf_q;
			end
			if (cmd.clr_start)
				idx_q <= '0;
			else if (cmd.clr_step)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.clr_start) begin
				flen_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	assign lcs_length = res_q;
endmodule

/* rtl/lcsl_ctrl.sv */
// Controller of the LCS length engine: accepts requests, sequences the row
// update, result capture and row clearing sweep. Depends on lcsl_pkg.
module lcsl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	output lcsl_pkg::cmd_t cmd,
	input lcsl_pkg::sts_t sts
);
	import lcsl_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_CAP
	} state_t;

	state_t state_q;
	logic started_q;
	logic acc;
	req_t req;

	assign req = req_t'(s_tdata[1:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		cmd.sym = s_tdata[9:2];
		cmd.store = acc && req == REQ_FIRST && !started_q;
		cmd.row_start = acc && req == REQ_SECOND && !sts.empty;
		cmd.row_step = (state_q == ST_ROW);
		cmd.rd_last = (acc && req == REQ_END) || (state_q == ST_CAP);
		cmd.capture = (state_q == ST_CAP) && !m_tvalid;
		cmd.clr_start = (state_q == ST_CAP) && !m_tvalid;
		cmd.clr_step = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			started_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						unique case (req)
							REQ_SECOND: begin
								started_q <= 1'b1;
								if (!sts.empty)
									state_q <= ST_ROW;
							end
							REQ_END: state_q <= ST_CAP;
							REQ_FIRST, REQ_NONE: ;
						endcase
					end
				end
				ST_ROW: begin
					if (sts.row_last)
						state_q <= ST_IDLE;
				end
				ST_CAP: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						started_q <= 1'b0;
						state_q <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end
endmodule

/* rtl/lcs_length_engine.sv */
// Top level of the LCS length engine: joins controller and datapath.
// Depends on lcsl_pkg, lcsl_ctrl and lcsl_datapath.
//
// channel | dir | tdata (low bit up)         | transfer
// s_axis  | in  | req_type[1:0], symbol[9:2] | one request
// m_axis  | out | lcs_length[8:0], ovf[9]    | one result per end of pair
//
// A first-string symbol is stored when it is taken; a second-string symbol,
// if a first string is stored, walks the row, one row cell per cycle through one shared cell.
// End of pair captures the result, then runs a row clearing sweep over all 256 entries;
// the sweep also runs after reset before the first request is taken.
// A waiting result holds the engine in its capture state after the next end
// of pair, stalling all input until the result is taken.
module lcs_length_engine (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // req_type, symbol
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata // lcs_length, overflow
);
	import lcsl_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [LEN_W-1:0] len;
	logic ovf;

	lcsl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	lcsl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.lcs_length(len), .overflow(ovf)
	);

	assign m_axis_tdata = {6'd0, ovf, len};
endmodule

/* rtl/lcsl_checker.sv */
// Port checker for the LCS length engine, bound to the top level.
// Depends on lcsl_pkg and the top-level ports.
module lcsl_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
		else $error("padding bits set");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd256)
		else $error("length out of range");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == lcsl_pkg::REQ_END
			|=> !s_axis_tready)
		else $error("request taken right after end of pair");
endmodule

bind lcs_length_engine lcsl_checker u_chk (.*);
